// File: rtl/ic3x3_pkg.sv
// Shared types and constants for the 3x3 image convolution core.
`timescale 1ns / 1ps

package ic3x3_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COEF_W      = 8;
    localparam int KERNEL_W    = 24;
    localparam int WIDTH_W     = 11;
    localparam int SHIFT_W     = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int RESULT_W    = 20;
    localparam int PROD_W      = 17;
    localparam int OUT_TDATA_W = 24;
    localparam int ROWS_W      = 2;

    // Output queue: depth, pointer and count widths
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int FIFO_CW     = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_SHIFT  = 3'd4;

    localparam logic [KERNEL_W-1:0] KERNEL_RESET      = 24'h0100FF;
    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET = 11'd640;

    // Item kinds on the input tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Completed-row counter saturates here
    localparam logic [ROWS_W-1:0] ROWS_FULL = 2'd2;

    // One window column: byte0 top row, byte1 middle row, byte2 bottom row
    typedef logic [KERNEL_W-1:0] column_t;

    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [RESULT_W-1:0] result_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PIXEL,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
        logic a_last;
        logic frame_end;
    } lane_flags_t;

    typedef struct packed {
        result_t     res_a;
        result_t     res_b;
        lane_flags_t flags;
    } fifo_entry_t;

    // Signed coefficient times unsigned pixel
    function automatic prod_t coef_mul(logic [COEF_W-1:0] coef, logic [PIXEL_W-1:0] pix);
        return $signed(coef) * $signed({1'b0, pix});
    endfunction

endpackage

// File: rtl/image_convolution_3x3_core.sv
// Top level of the streaming 3x3 image convolution core with replicated borders.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one transaction per item. tuser[0] is the kind:
//   pixel (tdata = 8-bit grey value, raster order) or flush. After the last
//   row of a frame, send image_width flush transactions to drain the bottom row.
//   Output stream (m_axis_*): one transaction per result; tdata[19:0] is the
//   signed, shifted weighted sum, tlast marks the final result of an input
//   item, tuser[0] marks the result for the frame's final pixel.
//   Results lag one row plus one pixel; the last pixel of a row gives two.
//   Configuration port: write kernel rows, image width and shift while idle.
// Timing
//   One item per clock sustained. An accepted item passes the stage 1, 2 and
//   3 registers, then its results are pushed into the output queue and
//   m_axis_tvalid rises. The rate is set by the read-modify-write of the
//   two line stores, each one RAM with one read and one write port per cycle.
//   s_axis_tready drops once queued entries plus items in the three stages
//   reach the 8-entry queue depth, so a stalled receiver backs up into the input.
// Reset
//   rst_n clears the pipeline, the queue, the frame position and loads the
//   register defaults; the line stores are not cleared and need no sweep.

module image_convolution_3x3_core
    import ic3x3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]             s_axis_tuser,   // [0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [19:0] filtered, [23:20] zero
    output logic                   m_axis_tlast,   // last_in_run
    output logic [0:0]             m_axis_tuser    // [0] frame_end
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KERNEL_W-1:0] kernel_top_reg;
    logic [KERNEL_W-1:0] kernel_middle_reg;
    logic [KERNEL_W-1:0] kernel_bottom_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [SHIFT_W-1:0]  result_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg    <= KERNEL_RESET;
            kernel_middle_reg <= KERNEL_RESET;
            kernel_bottom_reg <= KERNEL_RESET;
            image_width_reg   <= IMAGE_WIDTH_RESET;
            result_shift_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KERNEL_TOP:    kernel_top_reg    <= cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_MIDDLE: kernel_middle_reg <= cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_BOTTOM: kernel_bottom_reg <= cfg_data[KERNEL_W-1:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[WIDTH_W-1:0];
                CFG_RESULT_SHIFT:  result_shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Index of the last column in use: width zero acts as one, width beyond
    // the line stores acts as their depth
    logic [CMP_W-1:0] width_ext;
    logic [AW-1:0]    w_last;

    assign width_ext = CMP_W'(image_width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            w_last = '0;
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            w_last = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = AW'(width_ext - CMP_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, frame position, line store read
    // ------------------------------------------------------------------
    logic              accept;
    logic              is_flush;
    logic              restart;
    logic [AW-1:0]     col_pos_reg, col_pos_next;
    logic [ROWS_W-1:0] rows_reg, rows_next;
    logic [AW-1:0]     flush_pos_reg, flush_pos_next;
    logic [AW-1:0]     col_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic              pix_last;
    logic [AW-1:0]     pix_col;
    logic              flush_ok;
    logic              fl_last;
    logic [AW-1:0]     fl_col;
    logic [AW-1:0]     fl_right;
    logic [AW-1:0]     rd_addr;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign is_flush = (s_axis_tuser[0] == KIND_FLUSH);

    // A pixel arriving in the middle of a flush abandons it and opens a new frame
    assign restart  = (flush_pos_reg != '0);
    assign col_eff  = restart ? '0 : col_pos_reg;
    assign rows_eff = restart ? '0 : rows_reg;

    // A position at or past the width in use is taken as the last column
    assign pix_last = (col_eff >= w_last);
    assign pix_col  = pix_last ? w_last : col_eff;

    // Flush only once a row is complete and no row is in progress
    assign flush_ok = (rows_reg != '0) && (col_pos_reg == '0);
    assign fl_last  = (flush_pos_reg >= w_last);
    assign fl_col   = fl_last ? w_last : flush_pos_reg;
    assign fl_right = fl_last ? fl_col : fl_col + AW'(1);

    // Flush reads the column to the right; its other two columns are held
    assign rd_addr  = is_flush ? fl_right : pix_col;

    always_comb
    begin
        col_pos_next   = col_pos_reg;
        rows_next      = rows_reg;
        flush_pos_next = flush_pos_reg;
        if (accept)
        begin
            if (!is_flush)
            begin
                flush_pos_next = '0;
                if (pix_last)
                begin
                    col_pos_next = '0;
                    rows_next    = (rows_eff == ROWS_FULL) ? ROWS_FULL : rows_eff + ROWS_W'(1);
                end
                else
                begin
                    col_pos_next = pix_col + AW'(1);
                    rows_next    = rows_eff;
                end
            end
            else if (flush_ok)
            begin
                if (fl_last)
                begin
                    flush_pos_next = '0;
                    rows_next      = '0;
                    col_pos_next   = '0;
                end
                else
                begin
                    flush_pos_next = fl_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            rows_reg      <= '0;
            flush_pos_reg <= '0;
        end
        else
        begin
            col_pos_reg   <= col_pos_next;
            rows_reg      <= rows_next;
            flush_pos_reg <= flush_pos_next;
        end
    end

    // Stage 1 control and payload
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic               s1_first_reg;
    logic               s1_second_reg;
    logic               s1_last_reg;
    logic               s1_rows1_reg;
    logic               s1_rows2_reg;
    logic               s1_fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_NONE;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept && !is_flush)
            begin
                s1_op_reg <= OP_PIXEL;
            end
            else if (accept && flush_ok)
            begin
                s1_op_reg <= OP_FLUSH;
            end
            else
            begin
                s1_op_reg <= OP_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= rd_addr;
        s1_pixel_reg <= s_axis_tdata;
        // Forward when the entry being read is written back in this same cycle
        s1_fwd_reg   <= s1_valid_reg && (s1_op_reg == OP_PIXEL) && (s1_addr_reg == rd_addr);
        if (is_flush)
        begin
            s1_first_reg  <= (fl_col == '0);
            s1_second_reg <= 1'b0;
            s1_last_reg   <= fl_last;
            s1_rows1_reg  <= 1'b1;
            s1_rows2_reg  <= (rows_reg == ROWS_FULL);
        end
        else
        begin
            s1_first_reg  <= (pix_col == '0);
            s1_second_reg <= (pix_col == AW'(1));
            s1_last_reg   <= pix_last;
            s1_rows1_reg  <= (rows_eff != '0);
            s1_rows2_reg  <= (rows_eff == ROWS_FULL);
        end
    end

    // ------------------------------------------------------------------
    // Line stores: upper holds the row two back, lower the row just before
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [PIXEL_W-1:0] ram_upper_rdata;
    logic [PIXEL_W-1:0] ram_lower_rdata;
    logic [PIXEL_W-1:0] up_rd;
    logic [PIXEL_W-1:0] lo_rd;

    assign ram_we = s1_valid_reg && (s1_op_reg == OP_PIXEL);

    ic3x3_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (lo_rd),
        .raddr (rd_addr),
        .rdata (ram_upper_rdata)
    );

    ic3x3_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_lower (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (s1_pixel_reg),
        .raddr (rd_addr),
        .rdata (ram_lower_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: merge read data, slide the window, write back
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] fwd_upper_reg;
    logic [PIXEL_W-1:0] fwd_lower_reg;
    logic [PIXEL_W-1:0] snap_upper_reg;   // column 0 of the row just finished
    logic [PIXEL_W-1:0] snap_lower_reg;
    column_t            win_left_reg;
    column_t            win_centre_reg;
    column_t            win_right_reg;
    column_t            flush_a_reg;      // previous flush centre column
    column_t            flush_b_reg;      // previous flush right column
    logic [PIXEL_W-1:0] top_rd;
    column_t            pix_col_new;
    column_t            flush_col_new;
    column_t            snap_col;
    column_t            a_cols [3];
    column_t            b_cols [3];
    lane_flags_t        s1_flags;

    assign up_rd  = s1_fwd_reg ? fwd_upper_reg : ram_upper_rdata;
    assign lo_rd  = s1_fwd_reg ? fwd_lower_reg : ram_lower_rdata;

    // Before the second row is complete, the row above replicates the middle row
    assign top_rd        = s1_rows2_reg ? up_rd : lo_rd;
    assign pix_col_new   = {s1_pixel_reg, lo_rd, top_rd};
    // Bottom border replicates the last row
    assign flush_col_new = {lo_rd, lo_rd, top_rd};
    assign snap_col      = {snap_lower_reg, snap_lower_reg,
                            s1_rows2_reg ? snap_upper_reg : snap_lower_reg};

    always_comb
    begin
        a_cols[0] = '0;
        a_cols[1] = '0;
        a_cols[2] = '0;
        b_cols[0] = '0;
        b_cols[1] = '0;
        b_cols[2] = '0;
        s1_flags  = '0;
        case (s1_op_reg)
            OP_PIXEL:
            begin
                // Lane A: result for the column to the left of this pixel
                a_cols[0] = s1_second_reg ? win_right_reg : win_centre_reg;
                a_cols[1] = win_right_reg;
                a_cols[2] = pix_col_new;
                // Lane B: result for the last column, right border replicated
                b_cols[0] = s1_first_reg ? pix_col_new : win_right_reg;
                b_cols[1] = pix_col_new;
                b_cols[2] = pix_col_new;
                s1_flags.a_valid   = s1_rows1_reg && !s1_first_reg;
                s1_flags.b_valid   = s1_rows1_reg && s1_last_reg;
                s1_flags.a_last    = !s1_last_reg;
                s1_flags.frame_end = 1'b0;
            end
            OP_FLUSH:
            begin
                a_cols[0] = s1_first_reg ? snap_col : flush_a_reg;
                a_cols[1] = s1_first_reg ? snap_col : flush_b_reg;
                a_cols[2] = flush_col_new;
                b_cols[0] = a_cols[0];
                b_cols[1] = a_cols[1];
                b_cols[2] = a_cols[2];
                s1_flags.a_valid   = 1'b1;
                s1_flags.b_valid   = 1'b0;
                s1_flags.a_last    = 1'b1;
                s1_flags.frame_end = s1_last_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (s1_op_reg == OP_PIXEL))
        begin
            fwd_upper_reg  <= lo_rd;
            fwd_lower_reg  <= s1_pixel_reg;
            win_left_reg   <= win_centre_reg;
            win_centre_reg <= win_right_reg;
            win_right_reg  <= pix_col_new;
            if (s1_first_reg)
            begin
                snap_upper_reg <= lo_rd;
                snap_lower_reg <= s1_pixel_reg;
            end
        end
        if (s1_valid_reg && (s1_op_reg == OP_FLUSH))
        begin
            flush_a_reg <= a_cols[1];
            flush_b_reg <= flush_col_new;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: coefficient products for both lanes
    // ------------------------------------------------------------------
    column_t     kernel_rows [3];
    logic        s2_valid_reg;
    lane_flags_t s2_flags_reg;
    prod_t       s2_prod_a_reg [3][3];
    prod_t       s2_prod_b_reg [3][3];

    assign kernel_rows[0] = kernel_top_reg;
    assign kernel_rows[1] = kernel_middle_reg;
    assign kernel_rows[2] = kernel_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_flags_reg <= s1_flags;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s2_prod_a_reg[k][j] <= coef_mul(kernel_rows[k][COEF_W*j +: COEF_W],
                                                a_cols[j][PIXEL_W*k +: PIXEL_W]);
                s2_prod_b_reg[k][j] <= coef_mul(kernel_rows[k][COEF_W*j +: COEF_W],
                                                b_cols[j][PIXEL_W*k +: PIXEL_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add the nine products per lane
    // ------------------------------------------------------------------
    result_t     row_sum_a [3];
    result_t     row_sum_b [3];
    result_t     sum_a;
    result_t     sum_b;
    logic        s3_valid_reg;
    lane_flags_t s3_flags_reg;
    result_t     s3_sum_a_reg;
    result_t     s3_sum_b_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_sum_a[k] = result_t'(s2_prod_a_reg[k][0]) + result_t'(s2_prod_a_reg[k][1])
                         + result_t'(s2_prod_a_reg[k][2]);
            row_sum_b[k] = result_t'(s2_prod_b_reg[k][0]) + result_t'(s2_prod_b_reg[k][1])
                         + result_t'(s2_prod_b_reg[k][2]);
        end
        sum_a = row_sum_a[0] + row_sum_a[1] + row_sum_a[2];
        sum_b = row_sum_b[0] + row_sum_b[1] + row_sum_b[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_flags_reg <= s2_flags_reg;
        s3_sum_a_reg <= sum_a;
        s3_sum_b_reg <= sum_b;
    end

    // ------------------------------------------------------------------
    // Output queue: one entry per item, up to two results each
    // ------------------------------------------------------------------
    fifo_entry_t          fifo_mem_reg [FIFO_DEPTH];
    fifo_entry_t          push_entry;
    fifo_entry_t          head;
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 half_reg, half_next;
    logic                 push;
    logic                 pop;
    logic                 out_xfer;
    logic                 show_a;
    result_t              out_res;
    logic [FIFO_CW-1:0]   inflight;

    // Arithmetic shift floors negative sums
    assign push_entry.res_a = s3_sum_a_reg >>> result_shift_reg;
    assign push_entry.res_b = s3_sum_b_reg >>> result_shift_reg;
    assign push_entry.flags = s3_flags_reg;

    // Drop items that produced nothing
    assign push = s3_valid_reg && (s3_flags_reg.a_valid || s3_flags_reg.b_valid);

    assign head     = fifo_mem_reg[rd_ptr_reg];
    assign show_a   = head.flags.a_valid && !half_reg;
    assign out_res  = show_a ? head.res_a : head.res_b;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    // Hold the entry after lane A when lane B still waits
    assign pop      = out_xfer && !(show_a && head.flags.b_valid);

    assign m_axis_tvalid   = (count_reg != '0);
    assign m_axis_tdata    = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_res};
    assign m_axis_tlast    = show_a ? head.flags.a_last : 1'b1;
    assign m_axis_tuser[0] = show_a ? head.flags.frame_end : 1'b0;

    // Reserve a queue slot for every item still in the pipeline
    assign inflight = count_reg + FIFO_CW'(s1_valid_reg) + FIFO_CW'(s2_valid_reg)
                    + FIFO_CW'(s3_valid_reg);
    assign s_axis_tready = (inflight < FIFO_CW'(FIFO_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end

        half_next = half_reg;
        if (out_xfer)
        begin
            half_next = show_a && head.flags.b_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            half_reg  <= half_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/ic3x3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module ic3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: dv/image_convolution_3x3_core_tb.sv
// Self-checking stream testbench for the 3x3 convolution core with a built-in pixel-level predictor.
`timescale 1ns / 1ps

module image_convolution_3x3_core_tb;

    import ic3x3_pkg::*;

    localparam int          MAX_W        = 1024;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned TAIL_CYCLES  = 12;    // lets the pipeline stages drain
    localparam int unsigned CYCLE_LIMIT  = 900000;
    localparam int unsigned PRINT_LIMIT  = 100;

    typedef struct packed {
        logic                 kind;
        logic [PIXEL_W-1:0]   pixel;
    } stream_item_t;

    typedef struct packed {
        result_t filtered;
        logic    last_in_run;
        logic    frame_end;
    } pixel_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata  = '0;   // [7:0] pixel
    logic [0:0]             s_axis_tuser  = '0;   // [0] kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [19:0] filtered, [23:20] zero
    logic                   m_axis_tlast;         // last_in_run
    logic [0:0]             m_axis_tuser;         // [0] frame_end

    image_convolution_3x3_core #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the line stores, the 3-column
    // window, the raster position and the register file.
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0]  upper_line [MAX_W];
    logic [PIXEL_W-1:0]  lower_line [MAX_W];
    column_t             win_left, win_centre, win_right;
    int unsigned         col_pos, flush_pos;
    logic [ROWS_W-1:0]   rows_done;
    logic [KERNEL_W-1:0] kernel_rows [3];
    logic [WIDTH_W-1:0]  image_width;
    logic [SHIFT_W-1:0]  shift_amt;

    stream_item_t        pixel_feed [$];     // items waiting for the driver
    pixel_result_t       filtered_due [$];   // results still owed by the core

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned random_count  = 0;

    // Handshake bookkeeping shared between the posedge sampler and the
    // negedge drivers (set on one edge, consumed on the other).
    bit           in_taken  = 1'b0;
    bit           out_taken = 1'b0;
    bit           sending   = 1'b0;
    int unsigned  send_gap  = 0;
    int unsigned  recv_gap  = 0;
    int unsigned  hold_left = 0;
    logic         send_burst = 1'b0;
    logic         recv_burst = 1'b0;
    stream_item_t cur_item;

    task automatic report_mismatch(string what);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void reset_model();
        for (int i = 0; i < MAX_W; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        win_left       = '0;
        win_centre     = '0;
        win_right      = '0;
        col_pos        = 0;
        flush_pos      = 0;
        rows_done      = '0;
        kernel_rows[0] = KERNEL_RESET;
        kernel_rows[1] = KERNEL_RESET;
        kernel_rows[2] = KERNEL_RESET;
        image_width    = IMAGE_WIDTH_RESET;
        shift_amt      = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KERNEL_TOP:    kernel_rows[0] = data[KERNEL_W-1:0];
            CFG_KERNEL_MIDDLE: kernel_rows[1] = data[KERNEL_W-1:0];
            CFG_KERNEL_BOTTOM: kernel_rows[2] = data[KERNEL_W-1:0];
            CFG_IMAGE_WIDTH:   image_width    = data[WIDTH_W-1:0];
            CFG_RESULT_SHIFT:  shift_amt      = data[SHIFT_W-1:0];
            default: ;
        endcase
    endfunction

    // Correlation of the window with the kernel, then floor shift.
    function automatic result_t weighted_sum(column_t left, column_t centre, column_t right);
        column_t taps [3];
        int      acc;
        int      coef;
        taps[0] = left;
        taps[1] = centre;
        taps[2] = right;
        acc     = 0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef = int'($signed(kernel_rows[r][8*c +: 8]));
                acc += coef * int'(taps[c][8*r +: 8]);
            end
        end
        return result_t'(acc >>> shift_amt);
    endfunction

    // Bottom-row column during the drain: the row below replicates the last row.
    function automatic column_t drain_column(int unsigned idx);
        logic [PIXEL_W-1:0] above;
        above = (rows_done >= ROWS_FULL) ? upper_line[idx] : lower_line[idx];
        return {lower_line[idx], lower_line[idx], above};
    endfunction

    function automatic void owe_result(result_t value, logic run_end, logic frm_end);
        pixel_result_t res;
        res.filtered    = value;
        res.last_in_run = run_end;
        res.frame_end   = frm_end;
        filtered_due.push_back(res);
    endfunction

    // Advance the predictor by one accepted item and queue what it owes.
    function automatic void predict_item(logic kind, logic [PIXEL_W-1:0] pix);
        int unsigned        w;
        int unsigned        c;
        int unsigned        f;
        int unsigned        fl;
        int unsigned        fr;
        logic               at_end;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] top;
        column_t            lcol;

        w = (image_width == 0) ? 1 : (image_width > MAX_W) ? MAX_W : image_width;

        if (kind == KIND_PIXEL)
        begin
            // a pixel in the middle of a drain starts a new frame
            if (flush_pos != 0)
            begin
                flush_pos = 0;
                rows_done = '0;
                col_pos   = 0;
            end
            c      = col_pos;
            at_end = (c >= w - 1);
            if (at_end)
                c = w - 1;
            mid = lower_line[c];
            top = (rows_done >= ROWS_FULL) ? upper_line[c] : mid;
            upper_line[c] = lower_line[c];
            lower_line[c] = pix;
            win_left   = win_centre;
            win_centre = win_right;
            win_right  = {pix, mid, top};
            if (rows_done >= 1)
            begin
                if (c >= 1)
                begin
                    lcol = (c == 1) ? win_centre : win_left;
                    owe_result(weighted_sum(lcol, win_centre, win_right), !at_end, 1'b0);
                end
                if (at_end)
                begin
                    lcol = (c == 0) ? win_right : win_centre;
                    owe_result(weighted_sum(lcol, win_right, win_right), 1'b1, 1'b0);
                end
            end
            if (at_end)
            begin
                col_pos = 0;
                if (rows_done < ROWS_FULL)
                    rows_done++;
            end
            else
                col_pos = c + 1;
        end
        else if (rows_done != 0 && col_pos == 0)
        begin
            f      = flush_pos;
            at_end = (f >= w - 1);
            if (at_end)
                f = w - 1;
            fl = (f == 0) ? 0 : f - 1;
            fr = at_end ? f : f + 1;
            owe_result(weighted_sum(drain_column(fl), drain_column(f), drain_column(fr)),
                       1'b1, at_end);
            if (at_end)
            begin
                flush_pos = 0;
                rows_done = '0;
                col_pos   = 0;
            end
            else
                flush_pos = f + 1;
        end
    endfunction

    // Per-transaction gap drawn at random, with bursts of back-to-back transactions.
    function automatic int unsigned pick_gap(inout logic burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------------------
    // Posedge sampler: accept transactions on both sides, run the
    // predictor on inputs and check outputs field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_taken = 1'b1;
                predict_item(s_axis_tuser[0], s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_taken = 1'b1;
                if (filtered_due.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d (tdata %h)",
                                              results_seen, m_axis_tdata));
                else
                begin
                    want = filtered_due.pop_front();
                    if (result_t'(m_axis_tdata[RESULT_W-1:0]) !== want.filtered)
                        report_mismatch($sformatf("result %0d filtered %0d, want %0d",
                                                  results_seen,
                                                  result_t'(m_axis_tdata[RESULT_W-1:0]),
                                                  want.filtered));
                    if (m_axis_tlast !== want.last_in_run)
                        report_mismatch($sformatf("result %0d last_in_run %b, want %b",
                                                  results_seen, m_axis_tlast,
                                                  want.last_in_run));
                    if (m_axis_tuser[0] !== want.frame_end)
                        report_mismatch($sformatf("result %0d frame_end %b, want %b",
                                                  results_seen, m_axis_tuser[0],
                                                  want.frame_end));
                end
            end
        end
    end

    // Watchdog: end the run if the stream stops moving.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: present the next pending item after its gap; hold valid
    // high across back-to-back transactions.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                sending  = 1'b0;
                send_gap = pick_gap(send_burst);
            end
            if (!sending)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pixel_feed.size() != 0)
                begin
                    cur_item = pixel_feed.pop_front();
                    sending  = 1'b1;
                    s_axis_tdata    <= cur_item.pixel;
                    s_axis_tuser[0] <= cur_item.kind;
                end
            end
            s_axis_tvalid <= sending;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready gaps, plus two long hold-offs that let the
    // output queue fill and back-pressure the input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic rdy;
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                results_seen++;
                recv_gap = pick_gap(recv_burst);
                if (results_seen == 100 || results_seen == 1200)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic kind, logic [PIXEL_W-1:0] pix);
        stream_item_t it;
        it.kind  = kind;
        it.pixel = pix;
        pixel_feed.push_back(it);
    endtask

    // Wait until every item is in and every result is out, then let the
    // pipeline drain so a register write cannot hit an item in flight.
    task automatic settle();
        do
            @(posedge clk);
        while (pixel_feed.size() != 0 || sending || filtered_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_filter(logic [KERNEL_W-1:0] k_top, logic [KERNEL_W-1:0] k_mid,
                                  logic [KERNEL_W-1:0] k_bot, logic [WIDTH_W-1:0] width,
                                  logic [SHIFT_W-1:0] shift);
        write_reg(CFG_KERNEL_TOP, CFG_DATA_W'(k_top));
        write_reg(CFG_KERNEL_MIDDLE, CFG_DATA_W'(k_mid));
        write_reg(CFG_KERNEL_BOTTOM, CFG_DATA_W'(k_bot));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(width));
        write_reg(CFG_RESULT_SHIFT, CFG_DATA_W'(shift));
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [KERNEL_W-1:0] pick_kernel_row();
        case ($urandom_range(0, 7))
            0:       return 24'h808080;
            1:       return 24'h7F7F7F;
            2:       return '0;
            default: return KERNEL_W'($urandom);
        endcase
    endfunction

    // Mostly narrow images so that frames are short; now and then width 0.
    function automatic logic [WIDTH_W-1:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 11'd1;
        if (r == 1)
            return 11'd0;
        if (r <= 3)
            return WIDTH_W'($urandom_range(2, 3));
        if (r <= 16)
            return WIDTH_W'($urandom_range(4, 12));
        return WIDTH_W'($urandom_range(13, 40));
    endfunction

    // One frame: rows of pixels with stray flushes, then the bottom-row drain.
    // A cut drain is abandoned by the first pixel of the next frame.
    task automatic queue_frame(int unsigned cols, int unsigned rows, bit cut_drain);
        int unsigned drains;
        if ($urandom_range(0, 5) == 0)
            push_item(KIND_FLUSH, PIXEL_W'($urandom));
        for (int unsigned r = 0; r < rows; r++)
        begin
            for (int unsigned c = 0; c < cols; c++)
            begin
                push_item(KIND_PIXEL, pick_pixel());
                // stray flush mid-row: ignored by the core
                if (c + 1 < cols && $urandom_range(0, 15) == 0)
                    push_item(KIND_FLUSH, PIXEL_W'($urandom));
            end
        end
        drains = cut_drain ? $urandom_range(1, cols - 1) : cols;
        repeat (drains) push_item(KIND_FLUSH, PIXEL_W'($urandom));
        if (!cut_drain && $urandom_range(0, 3) == 0)
            push_item(KIND_FLUSH, PIXEL_W'($urandom));
        random_count += rows * cols + drains;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [WIDTH_W-1:0] w;
        int unsigned        w_eff;
        int unsigned        frames;
        bit                 cut;

        reset_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Most negative kernel on saturated pixels: lowest possible sum.
        // Flushes with nothing pending and mid-row are both dropped.
        program_filter(24'h808080, 24'h808080, 24'h808080, 11'd3, 4'd0);
        push_item(KIND_FLUSH, 8'hA5);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_FLUSH, 8'h5A);
        repeat (5) push_item(KIND_PIXEL, 8'hFF);
        repeat (3) push_item(KIND_FLUSH, 8'h00);
        settle();

        // Width 0 behaves as a single column; largest kernel, largest shift.
        program_filter(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 11'd0, 4'd15);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_PIXEL, 8'h00);
        push_item(KIND_FLUSH, 8'hFF);
        settle();

        // Narrow the image mid-row: the column past the new width closes the
        // row. Then break the drain with a pixel that opens a fresh frame.
        program_filter(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 11'd4, 4'd3);
        repeat (6) push_item(KIND_PIXEL, pick_pixel());
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(2));
        repeat (3) push_item(KIND_PIXEL, pick_pixel());
        push_item(KIND_FLUSH, 8'h3C);
        push_item(KIND_PIXEL, pick_pixel());
        push_item(KIND_PIXEL, pick_pixel());
        repeat (2) push_item(KIND_FLUSH, 8'hC3);
        settle();

        // Random phases: new registers at each frame boundary.
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            w = pick_width();
            program_filter(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), w,
                           SHIFT_W'($urandom_range(0, 15)));
            w_eff  = (w == 0) ? 1 : w;
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++)
            begin
                cut = (f + 1 < frames) && (w_eff > 1) && ($urandom_range(0, 4) == 0);
                queue_frame(w_eff, $urandom_range(1, 4), cut);
            end
            settle();
        end

        // Widest image, then a width above the line store depth, which clamps.
        program_filter(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 11'd1024,
                       SHIFT_W'($urandom_range(0, 15)));
        queue_frame(MAX_W, 1, 1'b0);
        settle();
        program_filter(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 11'd2047,
                       SHIFT_W'($urandom_range(0, 15)));
        queue_frame(MAX_W, 1, 1'b0);
        settle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
